// ----- design/mmfs_pkg.sv -----
package mmfs_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int POS_W      = 10;   // column / row position
  localparam int SIZE_W     = 11;   // configured width / height

  // accumulator and arithmetic widths
  localparam int PIX_W   = 8;
  localparam int N_W     = 21;      // pixels per frame
  localparam int SUM_W   = 28;
  localparam int SQ_W    = 36;
  localparam int CNT_W   = 19;
  localparam int MUL_W   = 28;      // shared multiplier operand
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DN_W    = 37;      // dev^2 * N
  localparam int SPLIT   = 18;      // low part of a split operand
  localparam int LHS_W   = 57;
  localparam int RHS_W   = 59;

  localparam logic [CNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [POS_W-1:0] POS_ONES   = '1;
  localparam logic [POS_W-1:0] BOX_MARGIN = POS_W'(10);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_THRESHOLD = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIMIT       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_TRIGGER  = CFG_IDX_W'(4);

  // frame record queue
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QFILL_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pixel_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] change_count;
    logic             deviation_ok;
    logic [9:0]       box_min_x;
    logic [9:0]       box_max_x;
    logic [9:0]       box_min_y;
    logic [9:0]       box_max_y;
    logic             frame_motion;
    logic             motion_confirmed;
  } result_word_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [7:0]        pixel_threshold;
    logic [7:0]        dev_limit;
    logic [CNT_W-1:0]  motion_trigger;
  } cfg_regs_t;

  // one finished frame, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [CNT_W-1:0]  cnt;
    logic [POS_W-1:0]  least_col;
    logic [POS_W-1:0]  greatest_col;
    logic [POS_W-1:0]  least_row;
    logic [POS_W-1:0]  greatest_row;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [7:0]        dev_limit;
    logic [CNT_W-1:0]  motion_trigger;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- design/motion_mask_frame_statistics.sv -----
// Motion-mask frame statistics. Takes one 8-bit mask pixel word per clock in raster
// order, tracks column and row from frame_width / frame_height, and at the last pixel
// of each frame delivers one result word: the changed-pixel count (even rows and
// columns at or above pixel_threshold), the widened bounding box, the stddev test
// against the deviation limit, and the frame / confirmed motion flags. Pixel input
// runs at one word per cycle; the end-of-frame test runs on a 28x28 multiplier
// sequencer in the back end, which waits in its done state on a result stall. Two
// finished frames can wait in the queue between front and back, so input only stalls
// when frames are shorter than about ten pixels or the result side holds off.
// Configuration is taken at any time (cfg_ready is always high); write it between
// frames. No clearing pass after reset.
module motion_mask_frame_statistics (
  input  logic                                 clk,
  input  logic                                 rst,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mmfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmfs_pkg::CFG_W-1:0]           cfg_data,
  // pixel words
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  mmfs_pkg::pixel_word_t                pixel_word,
  // result words
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output mmfs_pkg::result_word_t               result_word
);
  import mmfs_pkg::*;

  cfg_regs_t     cfg;
  logic          push, pop;
  frame_rec_t    push_rec, head;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  // register file; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width     <= SIZE_W'(640);
      cfg.frame_height    <= SIZE_W'(480);
      cfg.pixel_threshold <= 8'd32;
      cfg.dev_limit       <= 8'd20;
      cfg.motion_trigger  <= CNT_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[SIZE_W-1:0];
        CFG_PIXEL_THRESHOLD: cfg.pixel_threshold <= cfg_data[7:0];
        CFG_DEV_LIMIT:       cfg.dev_limit       <= cfg_data[7:0];
        CFG_MOTION_TRIGGER:  cfg.motion_trigger  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front: position tracking and per-frame accumulation
  mmfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel_word (pixel_word),
    .q_status   (q_status),
    .push       (push),
    .push_rec   (push_rec)
  );

  // finished-frame records
  mmfs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  // back: deviation test, box widening, motion flags, output register
  mmfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_word (result_word)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("frame record pushed into full queue");

  // no changes means an all-zero box
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_word.change_count == '0)) |->
      (result_word.box_min_x == '0) && (result_word.box_max_x == '0) &&
      (result_word.box_min_y == '0) && (result_word.box_max_y == '0))
    else $error("nonzero box with zero change count");

  // failed deviation test zeroes the count
  a_dev_fail: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_word.deviation_ok) |-> (result_word.change_count == '0))
    else $error("count reported with failed deviation test");

  // confirmation needs motion on this frame
  a_confirm: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_word.motion_confirmed) |-> result_word.frame_motion)
    else $error("motion confirmed without frame motion");
`endif

endmodule

// ----- design/mmfs_front.sv -----
module mmfs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  mmfs_pkg::cfg_regs_t   cfg,
  input  logic                  pixel_valid,
  output logic                  pixel_ready,
  input  mmfs_pkg::pixel_word_t pixel_word,
  input  mmfs_pkg::queue_status_t q_status,
  output logic                  push,
  output mmfs_pkg::frame_rec_t  push_rec
);
  import mmfs_pkg::*;

  logic [POS_W-1:0] column_pos, row_pos;
  logic [SUM_W-1:0] pixel_sum;
  logic [SQ_W-1:0]  pixel_square_sum;
  logic [CNT_W-1:0] changed_count;
  logic [POS_W-1:0] least_column, greatest_column, least_row, greatest_row;

  logic              fs, accept, sampled, col_end, row_end, last;
  logic [POS_W-1:0]  col, row;
  logic [SUM_W-1:0]  sum_b, sum_next;
  logic [SQ_W-1:0]   sq_b, sq_next;
  logic [CNT_W-1:0]  cnt_b, cnt_next;
  logic [POS_W-1:0]  lc_b, gc_b, lr_b, gr_b, lc_next, gc_next, lr_next, gr_next;
  logic [15:0]       pix_sq;
  logic [SIZE_W-1:0] w, h;

  assign pixel_ready = !q_status.full;
  assign accept      = pixel_valid && pixel_ready;
  assign fs          = pixel_word.frame_start;

  // frame start drops whatever partial frame is in flight
  assign col   = fs ? '0 : column_pos;
  assign row   = fs ? '0 : row_pos;
  assign sum_b = fs ? '0 : pixel_sum;
  assign sq_b  = fs ? '0 : pixel_square_sum;
  assign cnt_b = fs ? '0 : changed_count;
  assign lc_b  = fs ? POS_ONES : least_column;
  assign gc_b  = fs ? '0 : greatest_column;
  assign lr_b  = fs ? POS_ONES : least_row;
  assign gr_b  = fs ? '0 : greatest_row;

  assign w = clamp_size(cfg.frame_width, SIZE_W'(MAX_WIDTH));
  assign h = clamp_size(cfg.frame_height, SIZE_W'(MAX_HEIGHT));

  assign pix_sq   = 16'(pixel_word.pixel) * 16'(pixel_word.pixel);
  assign sum_next = sum_b + SUM_W'(pixel_word.pixel);
  assign sq_next  = sq_b + SQ_W'(pix_sq);

  assign sampled = !col[0] && !row[0] && (pixel_word.pixel >= cfg.pixel_threshold);

  always_comb begin
    cnt_next = cnt_b;
    lc_next  = lc_b;
    gc_next  = gc_b;
    lr_next  = lr_b;
    gr_next  = gr_b;
    if (sampled) begin
      if (cnt_b != COUNT_MAX) begin
        cnt_next = cnt_b + CNT_W'(1);
      end
      if (col < lc_b) lc_next = col;
      if (col > gc_b) gc_next = col;
      if (row < lr_b) lr_next = row;
      if (row > gr_b) gr_next = row;
    end
  end

  // a column or row past a shrunken size also ends the line / frame
  assign col_end = (SIZE_W'(col) + SIZE_W'(1)) >= w;
  assign row_end = (SIZE_W'(row) + SIZE_W'(1)) >= h;
  assign last    = col_end && row_end;
  assign push    = accept && last;

  always_comb begin
    push_rec.sum            = sum_next;
    push_rec.sq             = sq_next;
    push_rec.cnt            = cnt_next;
    push_rec.least_col      = lc_next;
    push_rec.greatest_col   = gc_next;
    push_rec.least_row      = lr_next;
    push_rec.greatest_row   = gr_next;
    push_rec.w              = w;
    push_rec.h              = h;
    push_rec.dev_limit      = cfg.dev_limit;
    push_rec.motion_trigger = cfg.motion_trigger;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      column_pos       <= '0;
      row_pos          <= '0;
      pixel_sum        <= '0;
      pixel_square_sum <= '0;
      changed_count    <= '0;
      least_column     <= POS_ONES;
      greatest_column  <= '0;
      least_row        <= POS_ONES;
      greatest_row     <= '0;
    end else if (accept) begin
      column_pos       <= col_end ? '0 : col + POS_W'(1);
      row_pos          <= col_end ? row + POS_W'(1) : row;
      pixel_sum        <= sum_next;
      pixel_square_sum <= sq_next;
      changed_count    <= cnt_next;
      least_column     <= lc_next;
      greatest_column  <= gc_next;
      least_row        <= lr_next;
      greatest_row     <= gr_next;
    end
  end

endmodule

// ----- design/mmfs_queue.sv -----
module mmfs_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mmfs_pkg::frame_rec_t    push_rec,
  input  logic                    pop,
  output mmfs_pkg::frame_rec_t    head,
  output mmfs_pkg::queue_status_t status
);
  import mmfs_pkg::*;

  frame_rec_t          slots [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QFILL_W-1:0]  fill;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head         = slots[rd_ptr];
  assign status.full  = (fill == QFILL_W'(Q_DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + QFILL_W'(1);
        2'b01:   fill <= fill - QFILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- design/mmfs_back.sv -----
module mmfs_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mmfs_pkg::queue_status_t q_status,
  input  mmfs_pkg::frame_rec_t    head,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_ready,
  output mmfs_pkg::result_word_t  result_word
);
  import mmfs_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DD   = 4'd1;
  localparam logic [3:0] ST_DN   = 4'd2;
  localparam logic [3:0] ST_LHS0 = 4'd3;
  localparam logic [3:0] ST_LHS1 = 4'd4;
  localparam logic [3:0] ST_RHS0 = 4'd5;
  localparam logic [3:0] ST_RHS1 = 4'd6;
  localparam logic [3:0] ST_SS   = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]        state, state_next;
  frame_rec_t        rec;
  logic [N_W-1:0]    n_reg;
  logic [DN_W-1:0]   dn;
  logic [PROD_W-1:0] prod, mul_out;
  logic [LHS_W-1:0]  lhs;
  logic [RHS_W-1:0]  rhs;
  logic              prev_motion;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              out_free, finish, ok, fm;
  logic [CNT_W-1:0]  count;
  logic [POS_W-1:0]  mnx, mxx, mny, mxy;
  logic [SIZE_W:0]   x_far, y_far;

  assign pop      = (state == ST_IDLE) && !q_status.empty;
  assign out_free = !result_valid || result_ready;
  assign finish   = (state == ST_DONE) && out_free;

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_DD: begin
        mul_a = MUL_W'(rec.dev_limit);
        mul_b = MUL_W'(rec.dev_limit);
      end
      ST_DN: begin
        mul_a = MUL_W'(prod[15:0]);
        mul_b = MUL_W'(n_reg);
      end
      ST_LHS0: begin
        mul_a = MUL_W'(n_reg);
        mul_b = MUL_W'(rec.sq[SPLIT-1:0]);
      end
      ST_LHS1: begin
        mul_a = MUL_W'(n_reg);
        mul_b = MUL_W'(rec.sq[SQ_W-1:SPLIT]);
      end
      ST_RHS0: begin
        mul_a = MUL_W'(dn[SPLIT-1:0]);
        mul_b = MUL_W'(n_reg);
      end
      ST_RHS1: begin
        mul_a = MUL_W'(dn[DN_W-1:SPLIT]);
        mul_b = MUL_W'(n_reg);
      end
      ST_SS: begin
        mul_a = MUL_W'(rec.sum);
        mul_b = MUL_W'(rec.sum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  always_comb begin
    case (state)
      ST_IDLE: state_next = pop ? ST_DD : ST_IDLE;
      ST_DD:   state_next = ST_DN;
      ST_DN:   state_next = ST_LHS0;
      ST_LHS0: state_next = ST_LHS1;
      ST_LHS1: state_next = ST_RHS0;
      ST_RHS0: state_next = ST_RHS1;
      ST_RHS1: state_next = ST_SS;
      ST_SS:   state_next = ST_ACC;
      ST_ACC:  state_next = ST_DONE;
      ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  // N*sumsq < dev^2*N^2 + sum^2
  assign ok    = RHS_W'(lhs) < rhs;
  assign count = ok ? rec.cnt : '0;
  assign fm    = count >= rec.motion_trigger;
  assign x_far = (SIZE_W + 1)'(rec.greatest_col) + (SIZE_W + 1)'(BOX_MARGIN) + (SIZE_W + 1)'(1);
  assign y_far = (SIZE_W + 1)'(rec.greatest_row) + (SIZE_W + 1)'(BOX_MARGIN) + (SIZE_W + 1)'(1);

  always_comb begin
    mnx = '0;
    mxx = '0;
    mny = '0;
    mxy = '0;
    if (count != '0) begin
      mnx = (rec.least_col > BOX_MARGIN) ? rec.least_col - BOX_MARGIN : rec.least_col;
      mny = (rec.least_row > BOX_MARGIN) ? rec.least_row - BOX_MARGIN : rec.least_row;
      mxx = (x_far < (SIZE_W + 1)'(rec.w)) ? rec.greatest_col + BOX_MARGIN
                                             : rec.greatest_col;
      mxy = (y_far < (SIZE_W + 1)'(rec.h)) ? rec.greatest_row + BOX_MARGIN
                                             : rec.greatest_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      prev_motion  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        result_valid <= 1'b1;
        prev_motion  <= fm;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_out;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          rec   <= head;
          n_reg <= N_W'(head.w) * N_W'(head.h);
        end
      end
      ST_LHS0: dn  <= prod[DN_W-1:0];
      ST_LHS1: lhs <= LHS_W'(prod);
      ST_RHS0: lhs <= lhs + LHS_W'({prod, {SPLIT{1'b0}}});
      ST_RHS1: rhs <= RHS_W'(prod);
      ST_SS:   rhs <= rhs + RHS_W'({prod, {SPLIT{1'b0}}});
      ST_ACC:  rhs <= rhs + RHS_W'(prod);
      ST_DONE: begin
        if (out_free) begin
          result_word.change_count     <= count;
          result_word.deviation_ok     <= ok;
          result_word.box_min_x        <= 10'(mnx);
          result_word.box_max_x        <= 10'(mxx);
          result_word.box_min_y        <= 10'(mny);
          result_word.box_max_y        <= 10'(mxy);
          result_word.frame_motion     <= fm;
          result_word.motion_confirmed <= fm && prev_motion;
        end
      end
      default: ;
    endcase
  end

endmodule
